// ===== design/vaos_pkg.sv =====
package vaos_pkg;

  localparam int unsigned VoicesDef = 8;
  localparam int unsigned MaxVoices = 8;
  localparam logic [31:0] TagStart  = 32'd23456;

  typedef enum logic [1:0] {
    KIND_ON   = 2'd0,
    KIND_OFF  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_START   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_FREED   = 2'd3
  } action_e;

  typedef enum logic {
    REG_VOICE_COUNT = 1'b0,
    REG_GROUP_MAP   = 1'b1
  } reg_idx_e;

endpackage

// ===== design/voice_allocator_oldest_steal_top.sv =====
// Polyphonic voice allocator with oldest-voice stealing.
// Input channel (in_valid_i / in_stall_o): one event beat per item: note on,
// note off or voice done. A beat is taken only while the block is idle.
// Output channel (out_valid_o / out_stall_i): one or more command beats per
// event; out_last_o marks the final beat of an event.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 voice_count, index 1
// group_map; ready is always high. Writes are to be made while the block
// is idle; the block itself does not enforce it. One sequencer walks the
// attached voices one per cycle with a single 32-bit tag comparator,
// pausing at a result while the output register is stalled. Note on: the
// free scan takes the first free voice of the group; when none is free,
// an oldest scan follows that steals the oldest voice of the group, or
// finds the group empty. Note off: a release beat for each matching
// voice, or a single no-match beat. Voice done: a single beat. The next
// event is taken in the cycle after the last beat is loaded; events of
// kind 3 are dropped.
// Results go through one output register; while out_stall_i holds it, the
// sequencer waits at its next result and resumes when the register drains.
// Reset frees every voice, clears notes, tags and sounding flags, sets the
// tag counter to 23456, voice_count to 8 and group_map to 0.
module voice_allocator_oldest_steal_top #(
  parameter int unsigned VOICES = vaos_pkg::VoicesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_kind_i,
  input  logic [6:0]  in_note_i,
  input  logic [6:0]  in_velocity_i,
  input  logic [3:0]  in_group_i,
  input  logic [2:0]  in_voice_sel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_action_o,
  output logic [2:0]  out_voice_o,
  output logic [31:0] out_tag_o,
  output logic [6:0]  out_note_out_o,
  output logic [6:0]  out_velocity_out_o,
  output logic [3:0]  out_active_count_o,
  output logic        out_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned NV = (VOICES < vaos_pkg::MaxVoices) ? VOICES : vaos_pkg::MaxVoices;
  localparam int unsigned IW = $clog2(NV);
  localparam int unsigned CW = $clog2(NV + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FREE = 5'b00010,
    S_OLD  = 5'b00100,
    S_OFF  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]  voice_count_q;
  logic [31:0] group_map_q;

  logic [NV-1:0] voice_free_q, voice_free_d;
  logic [NV-1:0] voice_sound_q, voice_sound_d;
  logic [6:0]    voice_note_q [NV];
  logic [6:0]    voice_note_d [NV];
  logic [31:0]   voice_tag_q  [NV];
  logic [31:0]   voice_tag_d  [NV];
  logic [31:0]   next_tag_q, next_tag_d;

  logic [6:0]  note_q, vel_q;
  logic [3:0]  grp_q;
  logic [2:0]  sel_q;
  logic [6:0]  note_d, vel_d;
  logic [3:0]  grp_d;
  logic [2:0]  sel_d;

  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] pick_q, pick_d;
  logic [31:0]   best_q, best_d;
  logic          have_q, have_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_action_q, out_action_d;
  logic [2:0]  out_voice_q, out_voice_d;
  logic [31:0] out_tag_q, out_tag_d;
  logic [6:0]  out_note_q, out_note_d;
  logic [6:0]  out_vel_q, out_vel_d;
  logic [3:0]  out_cnt_q, out_cnt_d;
  logic        out_last_q, out_last_d;

  logic [CW-1:0] n_att;
  logic [NV-1:0] att_mask, grp_hit, off_hit, above_mask;
  logic [IW-1:0] scan_ix, rd_ix;
  logic [31:0]   tag_rd;
  logic          tag_less;
  logic          out_rdy, in_acc, at_end, emit_start;
  logic [3:0]    cnt;

  assign n_att = (voice_count_q > 4'(NV)) ? CW'(NV) : CW'(voice_count_q);
  assign scan_ix = idx_q[IW-1:0];
  assign at_end = (idx_q == n_att);

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      att_mask[i]   = (CW'(i) < n_att);
      grp_hit[i]    = att_mask[i] && (group_map_q[4*i +: 4] == grp_q);
      off_hit[i]    = grp_hit[i] && !voice_free_q[i] && (voice_note_q[i] == note_q);
      above_mask[i] = (CW'(i) > idx_q);
    end
  end

  // single read port into the tag file and the shared comparator
  assign rd_ix    = (state_q == S_DONE) ? sel_q[IW-1:0] : scan_ix;
  assign tag_rd   = voice_tag_q[rd_ix];
  assign tag_less = tag_rd < best_q;

  assign out_rdy = !out_valid_q || !out_stall_i;
  assign in_acc  = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    cnt = '0;
    for (int i = 0; i < NV; i++) begin
      cnt = cnt + 4'(voice_sound_d[i] & att_mask[i]);
    end
  end

  always_comb begin
    state_d       = state_q;
    voice_free_d  = voice_free_q;
    voice_sound_d = voice_sound_q;
    voice_note_d  = voice_note_q;
    voice_tag_d   = voice_tag_q;
    next_tag_d    = next_tag_q;
    note_d        = note_q;
    vel_d         = vel_q;
    grp_d         = grp_q;
    sel_d         = sel_q;
    idx_d         = idx_q;
    pick_d        = pick_q;
    best_d        = best_q;
    have_d        = have_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_action_d  = out_action_q;
    out_voice_d   = out_voice_q;
    out_tag_d     = out_tag_q;
    out_note_d    = out_note_q;
    out_vel_d     = out_vel_q;
    out_last_d    = out_last_q;
    emit_start    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          note_d = in_note_i;
          vel_d  = in_velocity_i;
          grp_d  = in_group_i;
          sel_d  = in_voice_sel_i;
          idx_d  = '0;
          have_d = 1'b0;
          unique case (vaos_pkg::kind_e'(in_kind_i))
            vaos_pkg::KIND_ON:   state_d = S_FREE;
            vaos_pkg::KIND_OFF:  state_d = S_OFF;
            vaos_pkg::KIND_DONE: state_d = S_DONE;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_FREE: begin
        if (at_end) begin
          state_d = S_OLD;
          idx_d   = '0;
          have_d  = 1'b0;
        end else if (voice_free_q[scan_ix] && grp_hit[scan_ix]) begin
          if (out_rdy) begin
            pick_d     = scan_ix;
            emit_start = 1'b1;
            state_d    = S_IDLE;
          end
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_OLD: begin
        if (at_end) begin
          if (out_rdy) begin
            state_d = S_IDLE;
            if (have_q) begin
              emit_start = 1'b1;
            end else begin
              out_valid_d  = 1'b1;
              out_action_d = vaos_pkg::ACT_NONE;
              out_voice_d  = '0;
              out_tag_d    = '0;
              out_note_d   = note_q;
              out_vel_d    = vel_q;
              out_last_d   = 1'b1;
            end
          end
        end else begin
          if (grp_hit[scan_ix] && (!have_q || tag_less)) begin
            pick_d = scan_ix;
            best_d = tag_rd;
            have_d = 1'b1;
          end
          idx_d = idx_q + CW'(1);
        end
      end
      S_OFF: begin
        if (at_end) begin
          if (out_rdy) begin
            out_valid_d  = 1'b1;
            out_action_d = vaos_pkg::ACT_NONE;
            out_voice_d  = '0;
            out_tag_d    = '0;
            out_note_d   = note_q;
            out_vel_d    = vel_q;
            out_last_d   = 1'b1;
            state_d      = S_IDLE;
          end
        end else if (off_hit[scan_ix]) begin
          if (out_rdy) begin
            voice_sound_d[scan_ix] = 1'b0;
            out_valid_d  = 1'b1;
            out_action_d = vaos_pkg::ACT_RELEASE;
            out_voice_d  = 3'(scan_ix);
            out_tag_d    = tag_rd;
            out_note_d   = note_q;
            out_vel_d    = vel_q;
            out_last_d   = ~|(off_hit & above_mask);
            idx_d        = idx_q + CW'(1);
            if (out_last_d) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_DONE: begin
        if (out_rdy) begin
          out_valid_d = 1'b1;
          out_voice_d = sel_q;
          out_vel_d   = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
          if (4'(sel_q) < 4'(n_att)) begin
            voice_free_d[sel_q[IW-1:0]]  = 1'b1;
            voice_sound_d[sel_q[IW-1:0]] = 1'b0;
            voice_note_d[sel_q[IW-1:0]]  = '0;
            out_action_d = vaos_pkg::ACT_FREED;
            out_tag_d    = tag_rd;
            out_note_d   = voice_note_q[sel_q[IW-1:0]];
          end else begin
            out_action_d = vaos_pkg::ACT_NONE;
            out_tag_d    = '0;
            out_note_d   = '0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (emit_start) begin
      voice_tag_d[pick_d]   = next_tag_q;
      voice_note_d[pick_d]  = note_q;
      voice_free_d[pick_d]  = 1'b0;
      voice_sound_d[pick_d] = 1'b1;
      next_tag_d   = next_tag_q + 32'd1;
      out_valid_d  = 1'b1;
      out_action_d = vaos_pkg::ACT_START;
      out_voice_d  = 3'(pick_d);
      out_tag_d    = next_tag_q;
      out_note_d   = note_q;
      out_vel_d    = vel_q;
      out_last_d   = 1'b1;
    end
  end

  assign out_cnt_d = (out_valid_d && !(out_valid_q && out_stall_i)) ? cnt : out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      voice_count_q <= 4'd8;
      group_map_q   <= '0;
      voice_free_q  <= '1;
      voice_sound_q <= '0;
      next_tag_q    <= vaos_pkg::TagStart;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < NV; i++) begin
        voice_note_q[i] <= '0;
        voice_tag_q[i]  <= '0;
      end
    end else begin
      state_q       <= state_d;
      voice_free_q  <= voice_free_d;
      voice_sound_q <= voice_sound_d;
      voice_note_q  <= voice_note_d;
      voice_tag_q   <= voice_tag_d;
      next_tag_q    <= next_tag_d;
      out_valid_q   <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (vaos_pkg::reg_idx_e'(cfg_index_i))
          vaos_pkg::REG_VOICE_COUNT: voice_count_q <= cfg_data_i[3:0];
          vaos_pkg::REG_GROUP_MAP:   group_map_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    note_q       <= note_d;
    vel_q        <= vel_d;
    grp_q        <= grp_d;
    sel_q        <= sel_d;
    idx_q        <= idx_d;
    pick_q       <= pick_d;
    best_q       <= best_d;
    have_q       <= have_d;
    out_action_q <= out_action_d;
    out_voice_q  <= out_voice_d;
    out_tag_q    <= out_tag_d;
    out_note_q   <= out_note_d;
    out_vel_q    <= out_vel_d;
    out_cnt_q    <= out_cnt_d;
    out_last_q   <= out_last_d;
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign out_action_o       = out_action_q;
  assign out_voice_o        = out_voice_q;
  assign out_tag_o          = out_tag_q;
  assign out_note_out_o     = out_note_q;
  assign out_velocity_out_o = out_vel_q;
  assign out_active_count_o = out_cnt_q;
  assign out_last_o         = out_last_q;

  // a sounding voice is never free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (voice_sound_q & voice_free_q) == '0)
    else $error("sounding voice marked free");

  // a new result beat is only produced by a busy sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) != S_IDLE))
    else $error("result beat from idle sequencer");

  // the tag counter steps by one on each start beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_start |=> (next_tag_q == $past(next_tag_q) + 32'd1))
    else $error("tag counter did not advance on start");

endmodule

// ===== sim/voice_allocator_oldest_steal_top_tb.sv =====
package vaos_tb_pkg;

  typedef struct packed {
    vaos_pkg::action_e action;
    logic [2:0]        voice;
    logic [31:0]       tag;
    logic [6:0]        note;
    logic [6:0]        vel;
    logic [3:0]        count;
    logic              last;
  } voice_cmd_t;

  typedef struct packed {
    vaos_pkg::kind_e kind;
    logic [6:0]      note;
    logic [6:0]      vel;
    logic [3:0]      grp;
    logic [2:0]      sel;
  } note_evt_t;

  class voice_alloc_model;
    logic [3:0]  voice_count;
    logic [31:0] group_map;
    bit          is_free[8];
    logic [6:0]  held_note[8];
    logic [31:0] stamp[8];
    bit          sounding[8];
    logic [31:0] next_stamp;
    voice_cmd_t  pending_cmds[$];
    int unsigned mismatches;

    function new();
      voice_count = 4'd8;
      group_map   = '0;
      next_stamp  = vaos_pkg::TagStart;
      mismatches  = 0;
      for (int v = 0; v < 8; v++) begin
        is_free[v]   = 1'b1;
        held_note[v] = '0;
        stamp[v]     = '0;
        sounding[v]  = 1'b0;
      end
    endfunction

    function void write_reg(vaos_pkg::reg_idx_e idx, logic [31:0] data);
      if (idx == vaos_pkg::REG_VOICE_COUNT) voice_count = data[3:0];
      else group_map = data;
    endfunction

    function int unsigned attached();
      return (voice_count > vaos_pkg::MaxVoices) ? vaos_pkg::MaxVoices : voice_count;
    endfunction

    function logic [3:0] group_of(int unsigned v);
      return group_map[4*v +: 4];
    endfunction

    function void emit(vaos_pkg::action_e act, logic [2:0] voice, logic [31:0] tag,
                       logic [6:0] note, logic [6:0] vel);
      voice_cmd_t  c;
      int unsigned n;
      n = 0;
      for (int v = 0; v < attached(); v++) if (sounding[v]) n++;
      c.action = act;
      c.voice  = voice;
      c.tag    = tag;
      c.note   = note;
      c.vel    = vel;
      c.count  = 4'(n);
      c.last   = 1'b0;
      pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    function void note_event(note_evt_t e);
      int          pick;
      int unsigned n;
      int unsigned first;
      logic [6:0]  old_note;
      n     = attached();
      pick  = -1;
      first = pending_cmds.size();
      case (e.kind)
        vaos_pkg::KIND_ON: begin
          for (int v = 0; v < n && pick < 0; v++)
            if (is_free[v] && group_of(v) == e.grp) pick = v;
          if (pick < 0)
            for (int v = 0; v < n; v++)
              if (group_of(v) == e.grp && (pick < 0 || stamp[v] < stamp[pick])) pick = v;
          if (pick < 0) begin
            emit(vaos_pkg::ACT_NONE, 3'd0, 32'd0, e.note, e.vel);
          end else begin
            stamp[pick]     = next_stamp;
            next_stamp      = next_stamp + 32'd1;
            held_note[pick] = e.note;
            is_free[pick]   = 1'b0;
            sounding[pick]  = 1'b1;
            emit(vaos_pkg::ACT_START, 3'(pick), stamp[pick], e.note, e.vel);
          end
        end
        vaos_pkg::KIND_OFF: begin
          for (int v = 0; v < n; v++) begin
            if (!is_free[v] && held_note[v] == e.note && group_of(v) == e.grp) begin
              sounding[v] = 1'b0;
              emit(vaos_pkg::ACT_RELEASE, 3'(v), stamp[v], e.note, e.vel);
            end
          end
          if (pending_cmds.size() == first)
            emit(vaos_pkg::ACT_NONE, 3'd0, 32'd0, e.note, e.vel);
        end
        vaos_pkg::KIND_DONE: begin
          if (e.sel < n) begin
            old_note          = held_note[e.sel];
            is_free[e.sel]    = 1'b1;
            sounding[e.sel]   = 1'b0;
            held_note[e.sel]  = '0;
            emit(vaos_pkg::ACT_FREED, e.sel, stamp[e.sel], old_note, 7'd0);
          end else begin
            emit(vaos_pkg::ACT_NONE, e.sel, 32'd0, 7'd0, 7'd0);
          end
        end
        default: ;
      endcase
      if (pending_cmds.size() > first) pending_cmds[pending_cmds.size()-1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_cmd(voice_cmd_t got);
      voice_cmd_t want;
      if (pending_cmds.size() == 0) begin
        report($sformatf("beat with nothing pending, action %0d voice %0d",
                         got.action, got.voice));
        return;
      end
      want = pending_cmds.pop_front();
      if (got.action !== want.action)
        report($sformatf("action got %0d want %0d", got.action, want.action));
      if (got.voice !== want.voice)
        report($sformatf("voice got %0d want %0d", got.voice, want.voice));
      if (got.tag !== want.tag)
        report($sformatf("tag got %0d want %0d", got.tag, want.tag));
      if (got.note !== want.note)
        report($sformatf("note got %0d want %0d", got.note, want.note));
      if (got.vel !== want.vel)
        report($sformatf("velocity got %0d want %0d", got.vel, want.vel));
      if (got.count !== want.count)
        report($sformatf("active count got %0d want %0d", got.count, want.count));
      if (got.last !== want.last)
        report($sformatf("last got %0d want %0d", got.last, want.last));
    endtask
  endclass
endpackage

module voice_allocator_oldest_steal_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        ev_valid = 1'b0;
  logic [1:0]  ev_kind  = '0;
  logic [6:0]  ev_note  = '0;
  logic [6:0]  ev_vel   = '0;
  logic [3:0]  ev_grp   = '0;
  logic [2:0]  ev_sel   = '0;
  logic        cmd_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  out_action_o;
  logic [2:0]  out_voice_o;
  logic [31:0] out_tag_o;
  logic [6:0]  out_note_out_o;
  logic [6:0]  out_velocity_out_o;
  logic [3:0]  out_active_count_o;
  logic        out_last_o;
  logic        cfg_ready_o;

  bit idling   = 1'b1;
  bit hold_req = 1'b0;

  vaos_tb_pkg::voice_alloc_model sb = new();

  voice_allocator_oldest_steal_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (ev_valid),
    .in_stall_o         (in_stall_o),
    .in_kind_i          (ev_kind),
    .in_note_i          (ev_note),
    .in_velocity_i      (ev_vel),
    .in_group_i         (ev_grp),
    .in_voice_sel_i     (ev_sel),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (cmd_stall),
    .out_action_o       (out_action_o),
    .out_voice_o        (out_voice_o),
    .out_tag_o          (out_tag_o),
    .out_note_out_o     (out_note_out_o),
    .out_velocity_out_o (out_velocity_out_o),
    .out_active_count_o (out_active_count_o),
    .out_last_o         (out_last_o),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  function automatic vaos_tb_pkg::note_evt_t make_evt(vaos_pkg::kind_e kind,
                                                      logic [6:0] note, logic [6:0] vel,
                                                      logic [3:0] grp, logic [2:0] sel);
    vaos_tb_pkg::note_evt_t e;
    e.kind = kind;
    e.note = note;
    e.vel  = vel;
    e.grp  = grp;
    e.sel  = sel;
    return e;
  endfunction

  // mostly events aimed at the groups and held notes of voices 0 to 7, some noise
  function automatic vaos_tb_pkg::note_evt_t rand_evt();
    vaos_tb_pkg::note_evt_t e;
    int unsigned            r;
    int unsigned            v;
    r = $urandom_range(0, 99);
    v = $urandom_range(0, 7);
    e.note = 7'($urandom);
    e.vel  = 7'($urandom);
    e.sel  = 3'($urandom);
    e.grp  = ($urandom_range(0, 9) < 8) ? sb.group_of(v) : 4'($urandom);
    if (r < 45) begin
      e.kind = vaos_pkg::KIND_ON;
    end else if (r < 75) begin
      e.kind = vaos_pkg::KIND_OFF;
      if ($urandom_range(0, 9) < 7) e.note = sb.held_note[v];
    end else if (r < 96) begin
      e.kind = vaos_pkg::KIND_DONE;
    end else begin
      e.kind = vaos_pkg::KIND_NONE;
    end
    return e;
  endfunction

  task automatic send_evt(vaos_tb_pkg::note_evt_t e);
    if (idling && $urandom_range(0, 3) == 0) begin
      ev_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    ev_valid <= 1'b1;
    ev_kind  <= e.kind;
    ev_note  <= e.note;
    ev_vel   <= e.vel;
    ev_grp   <= e.grp;
    ev_sel   <= e.sel;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_event(e);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned            n;
    vaos_tb_pkg::note_evt_t e;
    n = 0;
    while (n < count) begin
      e = rand_evt();
      send_evt(e);
      if (e.kind != vaos_pkg::KIND_NONE) n++;
    end
  endtask

  // dropped events leave no beat behind, so wait out the longest scan too
  task automatic settle();
    ev_valid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] count_word, logic [31:0] map);
    cfg_valid <= 1'b1;
    cfg_index <= vaos_pkg::REG_VOICE_COUNT;
    cfg_data  <= count_word;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(vaos_pkg::REG_VOICE_COUNT, count_word);
    cfg_index <= vaos_pkg::REG_GROUP_MAP;
    cfg_data  <= map;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(vaos_pkg::REG_GROUP_MAP, map);
    cfg_valid <= 1'b0;
  endtask

  initial begin : cmd_sink
    int unsigned            stall_left;
    vaos_tb_pkg::voice_cmd_t got;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !cmd_stall) begin
        got.action = vaos_pkg::action_e'(out_action_o);
        got.voice  = out_voice_o;
        got.tag    = out_tag_o;
        got.note   = out_note_out_o;
        got.vel    = out_velocity_out_o;
        got.count  = out_active_count_o;
        got.last   = out_last_o;
        sb.check_cmd(got);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 80;
      end
      if (stall_left > 0) begin
        cmd_stall <= 1'b1;
        stall_left--;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        cmd_stall  <= 1'b1;
        stall_left = $urandom_range(0, 6);
      end else begin
        cmd_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setup: eight voices, all in group 0
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd0,   7'd127, 4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd127, 7'd0,   4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd60,  7'd64,  4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd60,  7'd65,  4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd61,  7'd1,   4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd62,  7'd2,   4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd63,  7'd3,   4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd64,  7'd4,   4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd65,  7'd5,   4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_OFF,  7'd60,  7'd10,  4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_OFF,  7'd60,  7'd11,  4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_OFF,  7'd99,  7'd12,  4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd1,   7'd13,  4'd15, 3'd0));
    send_evt(make_evt(vaos_pkg::KIND_OFF,  7'd127, 7'd14,  4'd15, 3'd0));
    send_evt(make_evt(vaos_pkg::KIND_DONE, 7'd0,   7'd0,   4'd0,  3'd2));
    send_evt(make_evt(vaos_pkg::KIND_DONE, 7'd0,   7'd0,   4'd0,  3'd2));
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd70,  7'd70,  4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_NONE, 7'd127, 7'd127, 4'd15, 3'd7));
    send_evt(make_evt(vaos_pkg::KIND_DONE, 7'd127, 7'd127, 4'd15, 3'd7));
    settle();

    // five attached voices, all in group 15
    configure(32'd5, 32'hFFFF_FFFF);
    send_evt(make_evt(vaos_pkg::KIND_DONE, 7'd0,   7'd0,   4'd0,  3'd6));
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd10,  7'd20,  4'd15, 3'd0));
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd11,  7'd21,  4'd0,  3'd0));
    send_evt(make_evt(vaos_pkg::KIND_DONE, 7'd0,   7'd0,   4'd15, 3'd4));
    send_evt(make_evt(vaos_pkg::KIND_ON,   7'd12,  7'd127, 4'd15, 3'd0));
    send_evt(make_evt(vaos_pkg::KIND_OFF,  7'd10,  7'd30,  4'd15, 3'd0));
    settle();

    configure(32'd8, 32'h7654_3210);
    run_random(25);
    settle();

    configure(32'd1, $urandom & 32'h3333_3333);
    hold_req = 1'b1;
    run_random(25);
    settle();

    configure(32'd0, $urandom);
    run_random(10);
    settle();

    configure({28'($urandom), 4'hF}, $urandom & 32'h1111_1111);
    run_random(20);
    settle();

    idling = 1'b0;
    configure($urandom_range(2, 7), $urandom & 32'h3333_3333);
    run_random(15);
    settle();

    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end
endmodule

// ===== voice_allocator_oldest_steal_top.f =====
design/vaos_pkg.sv
design/voice_allocator_oldest_steal_top.sv
sim/voice_allocator_oldest_steal_top_tb.sv
